// ===== hw/rtl/orse_pkg.sv =====
// Package for the 1-Wire ROM search engine.
// Holds the command and outcome codes, the search state and result records,
// and the bit-serial Dallas CRC-8 step. No dependencies.
package orse_pkg;

	// Request kinds carried on s_tuser
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_TARGET = 2'd1,
		CMD_START  = 2'd2,
		CMD_BITS   = 2'd3
	} cmd_t;

	// Result outcome codes
	typedef enum logic [1:0] {
		OUT_ACK   = 2'd0,
		OUT_FOUND = 2'd1,
		OUT_FAIL  = 2'd2
	} outcome_t;

	localparam logic [7:0] SEARCH_NORMAL = 8'hF0;
	localparam logic [7:0] SEARCH_COND   = 8'hEC;
	localparam logic [6:0] ROM_LAST_POS  = 7'd64;
	localparam logic [6:0] FAMILY_LIMIT  = 7'd9;
	localparam logic [6:0] CRC_LAST_POS  = 7'd56;
	localparam logic [7:0] CRC_POLY      = 8'h8C;

	// Search state kept between requests
	typedef struct packed {
		logic [63:0] rom;
		logic [6:0]  last_disc;
		logic [3:0]  family_disc;
		logic        last_dev;
		logic        pass_active;
		logic [6:0]  bit_pos;
		logic [6:0]  zero_pos;
		logic [7:0]  crc;
	} state_t;

	localparam state_t STATE_RESET = '{
		rom:         64'd0,
		last_disc:   7'd0,
		family_disc: 4'd0,
		last_dev:    1'b0,
		pass_active: 1'b0,
		bit_pos:     7'd1,
		zero_pos:    7'd0,
		crc:         8'd0
	};

	// One result item, laid out as on m_tdata (last member in the lowest bits)
	typedef struct packed {
		logic [3:0]  family_discrepancy;
		logic        last_device_flag;
		logic [63:0] rom_id;
		outcome_t    outcome;
		logic        write_bit;
		logic        write_bit_valid;
		logic [7:0]  send_byte;
		logic        send_byte_valid;
	} result_t;

	// Dallas CRC-8, one data bit, LSB first
	function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic din);
		logic fb;
		fb = crc[0] ^ din;
		crc8_bit = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'd0);
	endfunction

endpackage

// ===== hw/rtl/orse_step.sv =====
// Next-state and result logic of the 1-Wire ROM search engine.
// Purely combinational; uses orse_pkg for codes, records and the CRC step.
module orse_step (
	input  orse_pkg::cmd_t    cmd,
	input  logic [7:0]        family,
	input  logic              mode,
	input  logic              presence,
	input  logic              id_bit,
	input  logic              complement_bit,
	input  orse_pkg::state_t  st,
	output orse_pkg::state_t  nxt,
	output orse_pkg::result_t res
);

	logic [5:0] idx;
	logic       dir;

	assign idx = st.bit_pos[5:0] - 6'd1;

	// Pick the branch direction for a bit pair
	always_comb begin
		if (id_bit != complement_bit) begin
			dir = id_bit;
		end else if (st.bit_pos < st.last_disc) begin
			dir = st.rom[idx];
		end else begin
			dir = (st.bit_pos == st.last_disc);
		end
	end

	// Update the search state and build the result
	always_comb begin
		nxt = st;
		res = '0;
		res.outcome = orse_pkg::OUT_ACK;
		case (cmd)
			orse_pkg::CMD_CLEAR: begin
				nxt = orse_pkg::STATE_RESET;
			end
			orse_pkg::CMD_TARGET: begin
				nxt = orse_pkg::STATE_RESET;
				nxt.rom = {56'd0, family};
				nxt.last_disc = orse_pkg::ROM_LAST_POS;
			end
			orse_pkg::CMD_START: begin
				nxt.pass_active = 1'b0;
				nxt.bit_pos = 7'd1;
				nxt.zero_pos = 7'd0;
				nxt.crc = 8'd0;
				if (st.last_dev || !presence) begin
					nxt.last_dev = 1'b0;
					nxt.last_disc = 7'd0;
					nxt.family_disc = 4'd0;
					res.outcome = orse_pkg::OUT_FAIL;
				end else begin
					nxt.pass_active = 1'b1;
					res.send_byte_valid = 1'b1;
					res.send_byte = mode ? orse_pkg::SEARCH_COND
						: orse_pkg::SEARCH_NORMAL;
				end
			end
			orse_pkg::CMD_BITS: begin
				if (st.pass_active) begin
					if (id_bit && complement_bit) begin
						// no device answered: drop the pass
						nxt.pass_active = 1'b0;
						nxt.last_dev = 1'b0;
						nxt.last_disc = 7'd0;
						nxt.family_disc = 4'd0;
						res.outcome = orse_pkg::OUT_FAIL;
					end else begin
						if (id_bit == complement_bit && !dir) begin
							nxt.zero_pos = st.bit_pos;
							if (st.bit_pos < orse_pkg::FAMILY_LIMIT) begin
								nxt.family_disc = st.bit_pos[3:0];
							end
						end
						nxt.rom[idx] = dir;
						if (st.bit_pos <= orse_pkg::CRC_LAST_POS) begin
							nxt.crc = orse_pkg::crc8_bit(st.crc, dir);
						end
						nxt.bit_pos = st.bit_pos + 7'd1;
						res.write_bit_valid = 1'b1;
						res.write_bit = dir;
						// last bit: close the pass and check the ROM
						if (st.bit_pos == orse_pkg::ROM_LAST_POS) begin
							nxt.pass_active = 1'b0;
							nxt.last_disc = nxt.zero_pos;
							if (nxt.zero_pos == 7'd0) begin
								nxt.last_dev = 1'b1;
							end
							if (nxt.rom[7:0] != 8'd0 && nxt.rom[63:56] == nxt.crc) begin
								res.outcome = orse_pkg::OUT_FOUND;
								res.rom_id = nxt.rom;
								res.last_device_flag = nxt.last_dev;
							end else begin
								nxt.last_dev = 1'b0;
								nxt.last_disc = 7'd0;
								nxt.family_disc = 4'd0;
								res.outcome = orse_pkg::OUT_FAIL;
							end
						end
					end
				end
			end
			default: begin
				nxt = st;
			end
		endcase
		res.family_discrepancy = nxt.family_disc;
	end

endmodule

// ===== hw/rtl/onewire_rom_search_engine.sv =====
// Top level of the 1-Wire ROM search engine: stream ports, input and
// result registers, search state. Uses orse_pkg and orse_step.
//
// Binary-tree ROM search for a 1-Wire master. Each request on s_* is a
// command (s_tuser): clear, target a family, start a pass, or one read bit
// pair; each request gives exactly one result on m_*. A start returns the
// search byte (F0 or EC) to send, a bit pair returns the direction bit to
// write, and after bit 64 the result reports found (with the ROM) or failed.
// The Dallas CRC-8 is accumulated bit by bit during the pass, so the final
// check is a single compare. Each request is held in the input register,
// passes through the combinational step logic and is written into the
// result register; a new request can be taken every cycle while the result
// register is empty or m_tready is high, and back-pressure on m_* stalls s_tready.
module onewire_rom_search_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] family, [8] mode, [9] presence, [10] id_bit,
	// [11] complement_bit, [15:12] zero
	input  logic [15:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] send_byte_valid, [8:1] send_byte, [9] write_bit_valid, [10] write_bit,
	// [12:11] outcome, [76:13] rom_id, [77] last_device_flag,
	// [81:78] family_discrepancy, [87:82] zero
	output logic [87:0] m_tdata
);

	logic              valid_s1;
	orse_pkg::cmd_t    cmd_s1;
	logic [7:0]        family_s1;
	logic              mode_s1;
	logic              presence_s1;
	logic              id_s1;
	logic              cmp_s1;
	orse_pkg::state_t  state_q;
	orse_pkg::state_t  state_nxt;
	orse_pkg::result_t res_nxt;
	orse_pkg::result_t out_q;
	logic              out_valid_q;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1      <= orse_pkg::cmd_t'(s_tuser);
			family_s1   <= s_tdata[7:0];
			mode_s1     <= s_tdata[8];
			presence_s1 <= s_tdata[9];
			id_s1       <= s_tdata[10];
			cmp_s1      <= s_tdata[11];
		end
	end

	orse_step u_step (
		.cmd            (cmd_s1),
		.family         (family_s1),
		.mode           (mode_s1),
		.presence       (presence_s1),
		.id_bit         (id_s1),
		.complement_bit (cmp_s1),
		.st             (state_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// Advance the search state as each request completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orse_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_pos >= 7'd1 && state_q.bit_pos <= 7'd65)
		else $error("bit position out of range");

	a_pass_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pass_active |-> state_q.bit_pos <= orse_pkg::ROM_LAST_POS)
		else $error("pass active beyond the last ROM bit");

	a_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.outcome == orse_pkg::OUT_FOUND |->
		res_nxt.write_bit_valid && !res_nxt.send_byte_valid && !state_nxt.pass_active)
		else $error("found result without the final bit");

	a_start_send: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.send_byte_valid |=> state_q.pass_active && state_q.bit_pos == 7'd1)
		else $error("search byte sent without a fresh pass");
`endif

endmodule
